[design/bfr_pkg.sv]
`default_nettype none
package bfr_pkg;
   localparam int MAX_DIM = 1024;
   localparam int ADDR_W = $clog2(MAX_DIM);
   localparam int SIZE_W = 11;
   localparam int CHAN_W = 16;
   localparam int PIX_W = 3 * CHAN_W;
   localparam int SUM_W = CHAN_W + 4;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int FIFO_DEPTH = 4;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);
   localparam logic [0:0] REG_IMAGE_SIZE = 1'b0;
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // ceil(2^24 / count), exact for sums below 2^20
   localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(16777216);
   localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(8388608);
   localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(5592406);
   localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(4194304);
   localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(2796203);
   localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(1864136);

   typedef struct packed {
      logic              frame_end;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } out_item_type;

   function automatic logic [RECIP_W-1:0] recip(input logic [1:0] cols,
                                                input logic [1:0] rows);
      logic [RECIP_W-1:0] r;
      case ({cols, rows})
         4'b0101: r = RECIP_1;
         4'b0110, 4'b1001: r = RECIP_2;
         4'b0111, 4'b1101: r = RECIP_3;
         4'b1010: r = RECIP_4;
         4'b1011, 4'b1110: r = RECIP_6;
         4'b1111: r = RECIP_9;
         default: r = RECIP_1;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

[design/bfr_ram.sv]
`default_nettype none
module bfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[design/bfr_fifo.sv]
`default_nettype none
module bfr_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_valid,
   input  wire bfr_pkg::out_item_type wr_item,
   output logic                       rd_valid,
   input  wire logic                  rd_ready,
   output bfr_pkg::out_item_type      rd_item
);
   localparam int PTR_W = $clog2(bfr_pkg::FIFO_DEPTH);

   bfr_pkg::out_item_type entry_ff [bfr_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;
   logic             pop;

   assign rd_valid = count_ff != '0;
   assign pop = rd_valid && rd_ready;
   assign rd_item = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (wr_valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_valid |-> (count_ff < (PTR_W+1)'(bfr_pkg::FIFO_DEPTH) || pop))
      else $error("fifo overflow");
endmodule
`default_nettype wire

[design/box_filter_3x3_rgb.sv]
// 3x3 box filter for square RGB images, 16-bit components.
// Input stream req_*: one request per pixel in row-major order, or a drain
// tick (tuser = 1) once all pixels of the frame are in; image_size + 1 drain
// ticks flush the remaining outputs. Drain ticks sent early are dropped.
// Output stream rsp_*: smoothed pixels in row-major order, tuser marks the
// last pixel of the frame, after which counters restart for a new frame.
// One request per cycle is taken while req_tready is high. Results lag the
// input stream by one row plus one pixel; a result passes the line RAM read,
// neighborhood sum and reciprocal multiply into the output queue in turn.
// Both line stores share one 1024 x 96 RAM, read and rewritten each request not dropped;
// back-to-back hits on one column are forwarded.
// A 4-entry output queue absorbs a stalled receiver; req_tready drops only
// when all four slots are held by results in flight or queued.
// Reset: image_size = 1024, counters and window cleared; no RAM clearing.
// csr_*: image_size at address 0; a write restarts the frame position.
`default_nettype none
module box_filter_3x3_rgb (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // red_in, green_in, blue_in
   input  wire logic        req_tuser,  // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // red_out, green_out, blue_out
   output logic             rsp_tuser,  // frame_end
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int AW = bfr_pkg::ADDR_W;
   localparam int SW = bfr_pkg::SIZE_W;
   localparam int PW = bfr_pkg::PIX_W;
   localparam int CW = bfr_pkg::CHAN_W;
   localparam int UW = bfr_pkg::SUM_W;
   localparam int RW = bfr_pkg::RECIP_W;
   localparam int QW = $clog2(bfr_pkg::FIFO_DEPTH + 1);

   logic [SW-1:0] size_ff;
   logic [AW-1:0] in_col_ff, out_col_ff;
   logic [SW-1:0] in_row_ff, out_row_ff;
   logic [QW-1:0] reserved_ff;

   logic          csr_write, accept, pop, ignore, pass, emit, done;
   logic [SW-1:0] side_w, col_eff, in_col_inc;
   logic [SW:0]   out_col_inc, out_row_inc, in_row_inc;
   logic [PW-1:0] px;
   logic          use_l, use_r, use_t, use_b, fwd;
   logic [1:0]    col_cnt, row_cnt;
   logic          size_sel;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign size_sel = csr_paddr[2] == bfr_pkg::REG_IMAGE_SIZE && csr_paddr[1:0] == 2'b00;
   assign csr_prdata = size_sel ? 32'(size_ff) : 32'd0;

   assign req_tready = reserved_ff < QW'(bfr_pkg::FIFO_DEPTH);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      if (size_ff == '0) side_w = SW'(1);
      else if (size_ff > SW'(bfr_pkg::MAX_DIM)) side_w = SW'(bfr_pkg::MAX_DIM);
      else side_w = size_ff;
      col_eff = (SW'(in_col_ff) >= side_w) ? '0 : SW'(in_col_ff);
      ignore = (req_tuser == bfr_pkg::OP_DRAIN) && (in_row_ff < side_w);
      pass = accept && !ignore;
      px = (req_tuser == bfr_pkg::OP_DRAIN || in_row_ff >= side_w) ? '0 : req_tdata;
      emit = (in_row_ff >= SW'(1) && col_eff >= SW'(1)) || in_row_ff >= SW'(2);
      out_col_inc = {1'b0, SW'(out_col_ff)} + 1'b1;
      out_row_inc = {1'b0, out_row_ff} + 1'b1;
      in_col_inc = col_eff + 1'b1;
      in_row_inc = {1'b0, in_row_ff} + 1'b1;
      use_l = out_col_ff != '0;
      use_r = out_col_inc < {1'b0, side_w};
      use_t = out_row_ff != '0;
      use_b = out_row_inc < {1'b0, side_w};
      col_cnt = 2'd1 + {1'b0, use_l} + {1'b0, use_r};
      row_cnt = 2'd1 + {1'b0, use_t} + {1'b0, use_b};
      done = emit && !use_r && !use_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= bfr_pkg::SIZE_RESET;
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (csr_write) begin
         if (size_sel) begin
            size_ff <= csr_pwdata[SW-1:0];
            in_col_ff <= '0;
            in_row_ff <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end
      end else if (pass) begin
         if (done) begin
            in_col_ff <= '0;
            in_row_ff <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            if (in_col_inc >= side_w) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_inc[SW-1:0];
            end else begin
               in_col_ff <= in_col_inc[AW-1:0];
            end
            if (emit) begin
               if (out_col_inc >= {1'b0, side_w}) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_inc[SW-1:0];
               end else begin
                  out_col_ff <= out_col_inc[AW-1:0];
               end
            end
         end
      end
   end

   // stage B: line RAM data back, neighborhood sum
   logic          b_valid_ff, b_emit_ff, b_done_ff, b_fwd_ff;
   logic [AW-1:0] b_addr_ff;
   logic [PW-1:0] b_px_ff;
   logic [3:0]    b_mask_ff;  // left, right, top, bottom
   logic [RW-1:0] b_recip_ff;
   logic [2*PW-1:0] ram_q, last_wr_ff, line_rd, line_wr;
   logic [PW-1:0] top_px, mid_px;
   logic [PW-1:0] win_ff [6];
   logic [PW-1:0] grid [9];
   logic [UW-1:0] sum [3];

   assign fwd = b_valid_ff && (b_addr_ff == col_eff[AW-1:0]);
   assign line_rd = b_fwd_ff ? last_wr_ff : ram_q;
   assign top_px = line_rd[PW-1:0];
   assign mid_px = line_rd[2*PW-1:PW];
   assign line_wr = {b_px_ff, mid_px};

   bfr_ram #(.WIDTH(2 * PW), .DEPTH(bfr_pkg::MAX_DIM)) u_lines (
      .clock  (clock),
      .wr_en  (b_valid_ff),
      .wr_addr(b_addr_ff),
      .wr_data(line_wr),
      .rd_addr(col_eff[AW-1:0]),
      .rd_data(ram_q)
   );

   always_comb begin
      logic ok;
      for (int j = 0; j < 3; j++) begin
         grid[j] = win_ff[j];
         grid[3+j] = win_ff[3+j];
      end
      grid[6] = top_px;
      grid[7] = mid_px;
      grid[8] = b_px_ff;
      for (int k = 0; k < 3; k++) begin
         sum[k] = '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               ok = !(i == 0 && !b_mask_ff[3]) && !(i == 2 && !b_mask_ff[2])
                    && !(j == 0 && !b_mask_ff[1]) && !(j == 2 && !b_mask_ff[0]);
               if (ok) sum[k] = sum[k] + UW'(grid[3*i+j][CW*k +: CW]);
            end
         end
      end
   end

   // stage C: divide by count via reciprocal multiply
   logic          c_valid_ff, c_done_ff;
   logic [UW-1:0] c_sum_ff [3];
   logic [RW-1:0] c_recip_ff;
   logic [UW+RW-1:0] prod [3];
   bfr_pkg::out_item_type q_item, rsp_item;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k] = (UW+RW)'(c_sum_ff[k]) * (UW+RW)'(c_recip_ff);
      end
      q_item.red = prod[0][bfr_pkg::RECIP_SHIFT +: CW];
      q_item.green = prod[1][bfr_pkg::RECIP_SHIFT +: CW];
      q_item.blue = prod[2][bfr_pkg::RECIP_SHIFT +: CW];
      q_item.frame_end = c_done_ff;
   end

   always_ff @(posedge clock) begin
      b_addr_ff <= col_eff[AW-1:0];
      b_px_ff <= px;
      b_fwd_ff <= fwd;
      b_emit_ff <= emit;
      b_done_ff <= done;
      b_mask_ff <= {use_l, use_r, use_t, use_b};
      b_recip_ff <= bfr_pkg::recip(col_cnt, row_cnt);
      c_done_ff <= b_done_ff;
      c_recip_ff <= b_recip_ff;
      for (int k = 0; k < 3; k++) c_sum_ff[k] <= sum[k];
      if (b_valid_ff) last_wr_ff <= line_wr;
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         reserved_ff <= '0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         b_valid_ff <= pass;
         c_valid_ff <= b_valid_ff && b_emit_ff;
         reserved_ff <= reserved_ff + QW'(pass && emit) - QW'(pop);
         if (b_valid_ff) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top_px;
            win_ff[4] <= mid_px;
            win_ff[5] <= b_px_ff;
         end
      end
   end

   bfr_fifo u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_valid(c_valid_ff),
      .wr_item (q_item),
      .rd_valid(rsp_tvalid),
      .rd_ready(rsp_tready),
      .rd_item (rsp_item)
   );

   assign pop = rsp_tvalid && rsp_tready;
   assign rsp_tdata = {rsp_item.blue, rsp_item.green, rsp_item.red};
   assign rsp_tuser = rsp_item.frame_end;

   a_reserved_bound: assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= QW'(bfr_pkg::FIFO_DEPTH))
      else $error("reserved slots exceed queue depth");

   a_emit_flows: assert property (@(posedge clock) disable iff (reset)
      (pass && emit) |=> (b_valid_ff && b_emit_ff))
      else $error("emitting request lost before sum stage");

   a_slot_held: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> reserved_ff != '0)
      else $error("result in flight without reserved slot");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (pass && done && !csr_write) |=> (out_col_ff == '0 && out_row_ff == '0
                                        && in_row_ff == '0 && in_col_ff == '0))
      else $error("counters not cleared at frame end");
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIX_W = bfr_pkg::PIX_W;
   localparam int CHAN_W = bfr_pkg::CHAN_W;
   localparam int MAX_DIM = bfr_pkg::MAX_DIM;
   localparam int SIZE_W = bfr_pkg::SIZE_W;
   localparam logic [2:0] CSR_ADDR_IMAGE_SIZE = 3'(4 * bfr_pkg::REG_IMAGE_SIZE);
   localparam int RANDOM_ITEMS = 380;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [PIX_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [PIX_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [2:0]       csr_paddr;
   logic [31:0]      csr_pwdata;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   box_filter_3x3_rgb u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // filter state mirror
   logic [PIX_W-1:0]  upper_rows [MAX_DIM];
   logic [PIX_W-1:0]  middle_rows [MAX_DIM];
   logic [PIX_W-1:0]  window [6];
   logic [SIZE_W-1:0] side_reg;
   int unsigned       in_col, in_row, out_col, out_row;

   bfr_pkg::out_item_type smoothed_q[$];
   int  mismatches = 0;
   int  pixels_sent = 0;
   int  drains_sent = 0;
   int  pixels_checked = 0;
   int  frames_seen = 0;
   int  long_hold = 0;
   int  stall_left = 0;
   bit  gaps_on = 1;
   bit  stalls_on = 1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned active_side();
      if (side_reg == 0) return 1;
      if (side_reg > MAX_DIM) return MAX_DIM;
      return side_reg;
   endfunction

   task automatic clear_position();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endtask

   task automatic smooth_step(input logic op, input logic [PIX_W-1:0] data);
      int unsigned n, r, c, orow, ocol, cnt;
      int unsigned sum [3];
      logic [PIX_W-1:0] px, top, mid;
      logic [PIX_W-1:0] cols [3][3];
      bit emit, done;
      bfr_pkg::out_item_type o;
      n = active_side();
      r = in_row;
      c = in_col;
      done = 0;
      if (c >= n) c = 0;
      if (op == bfr_pkg::OP_DRAIN) begin
         if (r < n) return;
         px = '0;
      end else if (r >= n) begin
         px = '0;
      end else begin
         px = data;
      end
      top = upper_rows[c];
      mid = middle_rows[c];
      upper_rows[c] = mid;
      middle_rows[c] = px;
      emit = (r >= 1 && c >= 1) || r >= 2;
      if (emit) begin
         orow = out_row;
         ocol = out_col;
         sum = '{0, 0, 0};
         cnt = 0;
         for (int j = 0; j < 3; j++) begin
            cols[0][j] = window[j];
            cols[1][j] = window[3 + j];
         end
         cols[2][0] = top;
         cols[2][1] = mid;
         cols[2][2] = px;
         for (int i = 0; i < 3; i++) begin
            if ((i == 0 && ocol == 0) || (i == 2 && ocol + 1 >= n)) continue;
            for (int j = 0; j < 3; j++) begin
               if ((j == 0 && orow == 0) || (j == 2 && orow + 1 >= n)) continue;
               for (int k = 0; k < 3; k++)
                  sum[k] += cols[i][j][CHAN_W*k +: CHAN_W];
               cnt++;
            end
         end
         if (cnt == 0) cnt = 1;
         o.red = CHAN_W'(sum[0] / cnt);
         o.green = CHAN_W'(sum[1] / cnt);
         o.blue = CHAN_W'(sum[2] / cnt);
         done = (orow + 1 >= n) && (ocol + 1 >= n);
         o.frame_end = done;
         smoothed_q.push_back(o);
         ocol++;
         if (ocol >= n) begin
            ocol = 0;
            orow++;
         end
         out_col = ocol;
         out_row = orow & 11'h7FF;
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = px;
      c++;
      if (c >= n) begin
         c = 0;
         r++;
      end
      in_col = c;
      in_row = r & 11'h7FF;
      if (done) clear_position();
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [PIX_W-1:0] p;
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 5))
            0: p[CHAN_W*k +: CHAN_W] = '0;
            1: p[CHAN_W*k +: CHAN_W] = '1;
            default: p[CHAN_W*k +: CHAN_W] = CHAN_W'($urandom);
         endcase
      end
      return p;
   endfunction

   task automatic send_request(input logic op, input logic [PIX_W-1:0] data);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      smooth_step(op, data);
      if (op == bfr_pkg::OP_DRAIN) drains_sent++;
      else pixels_sent++;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (smoothed_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_side(input logic [31:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_IMAGE_SIZE;
      csr_pwdata <= value;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      side_reg = value[SIZE_W-1:0];
      clear_position();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // one frame: pixels, optional early drains, then the flush with optional extra pixels
   task automatic send_frame(input int unsigned n, input bit noisy);
      for (int unsigned i = 0; i < n * n; i++) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_request(bfr_pkg::OP_DRAIN, PIX_W'({$urandom, $urandom}));
         send_request(bfr_pkg::OP_PIXEL, random_pixel());
      end
      for (int unsigned i = 0; i <= n; i++) begin
         if (noisy && $urandom_range(0, 4) == 0)
            send_request(bfr_pkg::OP_PIXEL, random_pixel());
         else
            send_request(bfr_pkg::OP_DRAIN, PIX_W'({$urandom, $urandom}));
      end
      frames_seen++;
   endtask

   task automatic test_size_restart();
      // over-range size, then restarts in the middle of a frame
      write_side(32'd2047);
      for (int i = 0; i < 40; i++) send_request(bfr_pkg::OP_PIXEL, random_pixel());
      write_side(32'd4);
      for (int i = 0; i < 7; i++) send_request(bfr_pkg::OP_PIXEL, random_pixel());
      wait_drained();
      write_side(32'd4);
      send_frame(4, 0);
      wait_drained();
   endtask

   task automatic test_edge_sizes();
      write_side(32'd0);
      send_frame(1, 0);
      wait_drained();
      write_side(32'd1);
      send_request(bfr_pkg::OP_DRAIN, '0);
      send_request(bfr_pkg::OP_PIXEL, '1);
      send_request(bfr_pkg::OP_DRAIN, '1);
      send_request(bfr_pkg::OP_PIXEL, '1);
      wait_drained();
      write_side(32'd2);
      for (int i = 0; i < 4; i++) send_request(bfr_pkg::OP_PIXEL, '1);
      for (int i = 0; i < 3; i++) send_request(bfr_pkg::OP_DRAIN, '0);
      wait_drained();
      write_side(32'd3);
      send_frame(3, 1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      write_side(32'd6);
      long_hold = 300;
      send_frame(6, 0);
      send_frame(6, 1);
      wait_drained();
   endtask

   task automatic test_random_frames();
      int unsigned n;
      int start;
      start = pixels_sent + drains_sent;
      while (pixels_sent + drains_sent - start < RANDOM_ITEMS) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
         write_side(32'(n));
         repeat ($urandom_range(1, 2)) send_frame(n, $urandom_range(0, 2) == 0);
         wait_drained();
      end
   endtask

   task automatic test_full_rate();
      gaps_on = 0;
      stalls_on = 0;
      write_side(32'd5);
      send_frame(5, 0);
      send_frame(5, 0);
      wait_drained();
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            rsp_tready <= 1'b0;
            long_hold--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 13);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      bfr_pkg::out_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (smoothed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result data=%h last=%b", rsp_tdata, rsp_tuser);
         end else begin
            want = smoothed_q.pop_front();
            pixels_checked++;
            if (rsp_tdata != {want.blue, want.green, want.red} ||
                rsp_tuser != want.frame_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: expected rgb %h/%h/%h last %b, got %h/%h/%h last %b",
                           pixels_checked, want.red, want.green, want.blue, want.frame_end,
                           rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser);
            end
         end
      end
   end

   initial begin
      #4ms;
      $display("box_filter_3x3_rgb regression: fail");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      side_reg = bfr_pkg::SIZE_RESET;
      clear_position();
      for (int i = 0; i < MAX_DIM; i++) begin
         upper_rows[i] = '0;
         middle_rows[i] = '0;
      end
      for (int i = 0; i < 6; i++) window[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_size_restart();
      test_edge_sizes();
      test_backpressure();
      test_random_frames();
      test_full_rate();

      wait_drained();
      if (smoothed_q.size() != 0) mismatches++;
      $display("covered %0d pixel and %0d drain requests over %0d frames, sizes 0..2047",
               pixels_sent, drains_sent, frames_seen);
      $display("%0d smoothed pixels checked, %0d mismatches", pixels_checked, mismatches);
      if (mismatches == 0)
         $display("box_filter_3x3_rgb regression: pass");
      else
         $display("box_filter_3x3_rgb regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
design/bfr_pkg.sv
design/bfr_ram.sv
design/bfr_fifo.sv
design/box_filter_3x3_rgb.sv
tb/sv/tb_top.sv
